>>> hw/rtl/irtm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irtm_pkg
// Shared constants, types and state encoding for the infrared ranger
// trimmed-mean filter.
// ----------------------------------------------------------------------------
package irtm_pkg;

  // window shape
  localparam int WINDOW   = 10;
  localparam int TRIM     = 2;
  localparam int TRIM_EFF = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
  localparam int KEPT     = WINDOW - 2 * TRIM_EFF;

  localparam int ADC_W  = 10;
  localparam int DIST_W = 16;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int IDX_W  = $clog2(WINDOW);
  localparam int SUM_W  = $clog2(KEPT * 65535 + 1);

  // distance conversion: 160000000 / (335 * sample - 70850)
  localparam int SCALED_W = 19;
  localparam int DIV_NW   = 28;
  localparam int DIV_DW   = 19;
  localparam int DIV_CW   = $clog2(DIV_NW + 1);

  localparam logic [DIV_NW-1:0]   DIST_NUM   = DIV_NW'(160000000);
  localparam logic [8:0]          ADC_SLOPE  = 9'd335;
  localparam logic [SCALED_W-1:0] ADC_OFFSET = SCALED_W'(70850);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GATE_HIGH = 1'b1;

  typedef struct packed {
    logic ins;
    logic clr;
  } irtm_sort_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DIST,
    ST_SUM,
    ST_AVG_GO,
    ST_AVG
  } irtm_state_t;

endpackage
`default_nettype wire

>>> hw/rtl/ir_range_trimmed_mean.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ir_range_trimmed_mean
// Infrared ranger filter: converts raw readings to Q12.4 cm distances,
// gates them and emits the trimmed mean of every full window.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carry one raw 10-bit reading per word. out_valid and
//   out_stall carry one 16-bit average per completed window.
//   cfg_we writes gate_low (index 0) or gate_high (index 1); write only while
//   the block is idle.
// Sequence:
//   a reading is accepted in ST_IDLE, scaled in ST_SCALE, converted by the
//   bit-serial divider in ST_DIST and then gated and inserted; a reading
//   with a non-positive denominator goes back to idle after scaling. The
//   reading that completes a window adds serial summing of the KEPT (6)
//   middle words in ST_SUM and the averaging divide before the result is
//   registered at the output. The shared divider gives one bit per cycle.
// Reset: clears the window count, the gates go to 0 and 65535, no output.
// Stall: the output register holds its word; readings are still taken, but
//   a ready average waits for a free register with in_stall held high.
// ----------------------------------------------------------------------------
module ir_range_trimmed_mean (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [irtm_pkg::ADC_W-1:0]        in_adc_sample,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [irtm_pkg::DIST_W-1:0]            out_average_distance,
  input  wire logic                              cfg_we,
  input  wire logic [irtm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [irtm_pkg::DIST_W-1:0]       cfg_wdata
);

  localparam int IDX_W = irtm_pkg::IDX_W;
  localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(irtm_pkg::TRIM_EFF);
  localparam logic [IDX_W-1:0] IDX_LAST  =
    IDX_W'(irtm_pkg::TRIM_EFF + irtm_pkg::KEPT - 1);

  irtm_pkg::irtm_state_t state_r, state_nxt;

  logic [irtm_pkg::DIST_W-1:0]   gate_low_r, gate_high_r;
  logic [irtm_pkg::ADC_W-1:0]    sample_r;
  logic [IDX_W-1:0]              idx_r;
  logic [irtm_pkg::SUM_W-1:0]    sum_r;
  logic [irtm_pkg::DIST_W-1:0]   out_data_r;
  logic                          out_valid_r;

  logic [irtm_pkg::SCALED_W-1:0] scaled;
  logic                          denom_ok;
  logic [irtm_pkg::DIST_W-1:0]   distance;
  logic                          in_gate;
  logic                          out_free;

  logic                          div_start, div_done;
  logic [irtm_pkg::DIV_NW-1:0]   div_dividend, div_quot;
  logic [irtm_pkg::DIV_DW-1:0]   div_divisor;

  irtm_pkg::irtm_sort_ctl_t      sort_ctl;
  logic [irtm_pkg::CNT_W-1:0]    sort_count;
  logic [irtm_pkg::DIST_W-1:0]   sort_rd;

  logic                          accept, sum_init, sum_step, out_load;

  irtm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  irtm_sort u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (sort_ctl),
    .ins_value (distance),
    .rd_idx    (idx_r),
    .count     (sort_count),
    .rd_data   (sort_rd)
  );

  // datapath around the divider
  always_comb begin
    scaled   = irtm_pkg::SCALED_W'(sample_r * irtm_pkg::ADC_SLOPE);
    denom_ok = scaled > irtm_pkg::ADC_OFFSET;
    distance = (|div_quot[irtm_pkg::DIV_NW-1:irtm_pkg::DIST_W]) ?
               '1 : div_quot[irtm_pkg::DIST_W-1:0];
    in_gate  = (distance >= gate_low_r) && (distance <= gate_high_r);
    out_free = !out_valid_r || !out_stall;
    if (state_r == irtm_pkg::ST_AVG_GO) begin
      div_dividend = irtm_pkg::DIV_NW'(sum_r);
      div_divisor  = irtm_pkg::DIV_DW'(irtm_pkg::KEPT);
    end else begin
      div_dividend = irtm_pkg::DIST_NUM;
      div_divisor  = irtm_pkg::DIV_DW'(scaled - irtm_pkg::ADC_OFFSET);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      irtm_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = irtm_pkg::ST_SCALE;
      end
      irtm_pkg::ST_SCALE: begin
        state_nxt = denom_ok ? irtm_pkg::ST_DIST : irtm_pkg::ST_IDLE;
      end
      irtm_pkg::ST_DIST: begin
        if (div_done) begin
          if (in_gate &&
              sort_count == irtm_pkg::CNT_W'(irtm_pkg::WINDOW - 1)) begin
            state_nxt = irtm_pkg::ST_SUM;
          end else begin
            state_nxt = irtm_pkg::ST_IDLE;
          end
        end
      end
      irtm_pkg::ST_SUM: begin
        if (idx_r == IDX_LAST) state_nxt = irtm_pkg::ST_AVG_GO;
      end
      irtm_pkg::ST_AVG_GO: begin
        state_nxt = irtm_pkg::ST_AVG;
      end
      irtm_pkg::ST_AVG: begin
        if (div_done && out_free) state_nxt = irtm_pkg::ST_IDLE;
      end
      default: state_nxt = irtm_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall     = 1'b1;
    accept       = 1'b0;
    div_start    = 1'b0;
    sort_ctl.ins = 1'b0;
    sort_ctl.clr = 1'b0;
    sum_init     = 1'b0;
    sum_step     = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      irtm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      irtm_pkg::ST_SCALE: begin
        div_start = denom_ok;
      end
      irtm_pkg::ST_DIST: begin
        sort_ctl.ins = div_done && in_gate;
        sum_init     = 1'b1;
      end
      irtm_pkg::ST_SUM: begin
        sum_step = 1'b1;
      end
      irtm_pkg::ST_AVG_GO: begin
        div_start = 1'b1;
      end
      irtm_pkg::ST_AVG: begin
        out_load     = div_done && out_free;
        sort_ctl.clr = out_load;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= irtm_pkg::ST_IDLE;
      gate_low_r  <= '0;
      gate_high_r <= '1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          irtm_pkg::REG_GATE_LOW:  gate_low_r  <= cfg_wdata;
          irtm_pkg::REG_GATE_HIGH: gate_high_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_adc_sample;
    end
    if (sum_init) begin
      idx_r <= IDX_FIRST;
      sum_r <= '0;
    end else if (sum_step) begin
      idx_r <= idx_r + IDX_W'(1);
      sum_r <= sum_r + irtm_pkg::SUM_W'(sort_rd);
    end
    if (out_load) begin
      out_data_r <= div_quot[irtm_pkg::DIST_W-1:0];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_average_distance = out_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/irtm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irtm_div
// Restoring divider, one quotient bit per cycle, shared by the distance
// conversion and the window average.
// ----------------------------------------------------------------------------
module irtm_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [irtm_pkg::DIV_NW-1:0]  dividend,
  input  wire logic [irtm_pkg::DIV_DW-1:0]  divisor,
  output logic                              done,
  output logic [irtm_pkg::DIV_NW-1:0]       quotient
);

  localparam int NW = irtm_pkg::DIV_NW;
  localparam int DW = irtm_pkg::DIV_DW;
  localparam int CW = irtm_pkg::DIV_CW;

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dsr_r;
  logic [CW-1:0] cnt_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          fits;

  always_comb begin
    shifted = {rem_r, quo_r[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr_r};
    fits    = ~diff[DW+1];
  end

  // dividend shifts out the top while quotient bits shift in the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      quo_r <= {quo_r[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= CW'(NW);
      done_r <= 1'b0;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> hw/rtl/irtm_sort.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irtm_sort
// Window store kept in ascending order: each new word is inserted in place
// by a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
module irtm_sort (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire irtm_pkg::irtm_sort_ctl_t      ctl,
  input  wire logic [irtm_pkg::DIST_W-1:0]   ins_value,
  input  wire logic [irtm_pkg::IDX_W-1:0]    rd_idx,
  output logic [irtm_pkg::CNT_W-1:0]         count,
  output logic [irtm_pkg::DIST_W-1:0]        rd_data
);

  localparam int N = irtm_pkg::WINDOW;

  logic [irtm_pkg::DIST_W-1:0] ent_r [N];
  logic [irtm_pkg::CNT_W-1:0]  count_r;
  logic [N-1:0]                keep;

  // a cell keeps its word when that word is valid and not above the new one
  always_comb begin
    for (int i = 0; i < N; i++) begin
      keep[i] = (irtm_pkg::CNT_W'(i) < count_r) && (ent_r[i] <= ins_value);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      for (int i = 0; i < N; i++) begin
        if (!keep[i]) begin
          if (i == 0) begin
            ent_r[i] <= ins_value;
          end else if (keep[i-1]) begin
            ent_r[i] <= ins_value;
          end else begin
            ent_r[i] <= ent_r[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctl.clr) begin
      count_r <= '0;
    end else if (ctl.ins) begin
      count_r <= count_r + irtm_pkg::CNT_W'(1);
    end
  end

  assign count   = count_r;
  assign rd_data = ent_r[rd_idx];

endmodule
`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the infrared ranger trimmed-mean filter. A short
// table of readings, some with hand-computed averages, comes first. Random
// readings then follow under several gate settings, with idle gaps on both
// channels. Each average is checked against the hand-computed row or else a
// cycle-free model of the conversion, gating and trimmed mean.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ADC_W     = irtm_pkg::ADC_W;
  localparam int DIST_W    = irtm_pkg::DIST_W;
  localparam int CFG_IDX_W = irtm_pkg::CFG_IDX_W;
  localparam int WINDOW    = irtm_pkg::WINDOW;
  localparam int TRIM      = irtm_pkg::TRIM;

  localparam int unsigned RANGE_NUM    = 160000000;
  localparam int unsigned RANGE_SLOPE  = 335;
  localparam int unsigned RANGE_OFFSET = 70850;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 100;
  localparam int N_DIRECTED   = 22;
  localparam int N_PHASES     = 7;

  typedef struct {
    logic [ADC_W-1:0]  sample;
    bit                typed;
    bit                gives_avg;
    logic [DIST_W-1:0] avg;
  } reading_row_t;

  typedef struct {
    logic [DIST_W-1:0] lo;
    logic [DIST_W-1:0] hi;
    int                smin;
    int                smax;
    int                count;
    int                snd_idle;
    int                rcv_idle;
  } gate_phase_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADC_W-1:0]     in_adc_sample;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIST_W-1:0]    out_average_distance;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [DIST_W-1:0]    cfg_wdata;

  // model state
  logic [DIST_W-1:0] gate_lo;
  logic [DIST_W-1:0] gate_hi;
  logic [DIST_W-1:0] win_dist [WINDOW];
  int unsigned       win_fill;

  logic [DIST_W-1:0] expected_averages [$];
  int                mismatch_cnt;
  int                quiet_cycles;
  int                snd_idle;
  int                rcv_idle;

  reading_row_t directed_rows [N_DIRECTED];
  gate_phase_t  gate_phases [N_PHASES];

  ir_range_trimmed_mean uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_adc_sample        (in_adc_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_average_distance (out_average_distance),
    .cfg_we               (cfg_we),
    .cfg_idx              (cfg_idx),
    .cfg_wdata            (cfg_wdata)
  );

  always #5 clk = ~clk;

  // raw reading to Q12.4 cm, zero return when the denominator is not positive
  function automatic bit distance_of(input logic [ADC_W-1:0] s,
                                     output logic [DIST_W-1:0] d);
    int unsigned scaled;
    int unsigned q;
    scaled = s * RANGE_SLOPE;
    d = '0;
    if (scaled <= RANGE_OFFSET) return 1'b0;
    q = RANGE_NUM / (scaled - RANGE_OFFSET);
    d = (q > 32'hFFFF) ? 16'hFFFF : q[DIST_W-1:0];
    return 1'b1;
  endfunction

  // gate one distance into the window, returns 1 with the trimmed mean when full
  function automatic bit window_average(input logic [DIST_W-1:0] d,
                                        output logic [DIST_W-1:0] avg);
    logic [DIST_W-1:0] srt [WINDOW];
    logic [DIST_W-1:0] key;
    int unsigned       trim;
    int unsigned       kept;
    int unsigned       sum;
    int                i;
    int                j;
    avg = '0;
    if (d < gate_lo || d > gate_hi) return 1'b0;
    if (win_fill >= WINDOW) win_fill = 0;
    win_dist[win_fill] = d;
    win_fill++;
    if (win_fill < WINDOW) return 1'b0;
    srt = win_dist;
    for (i = 1; i < WINDOW; i++) begin
      key = srt[i];
      j = i;
      while (j > 0 && srt[j-1] > key) begin
        srt[j] = srt[j-1];
        j--;
      end
      srt[j] = key;
    end
    trim = (2 * TRIM >= WINDOW) ? (WINDOW - 1) / 2 : TRIM;
    kept = WINDOW - 2 * trim;
    sum = 0;
    for (i = trim; i < trim + kept; i++) sum += srt[i];
    avg = DIST_W'(sum / kept);
    win_fill = 0;
    return 1'b1;
  endfunction

  // called right after a falling edge, returns right after a falling edge
  task automatic feed_reading(input logic [ADC_W-1:0] s, input bit typed,
                              input bit gives_avg, input logic [DIST_W-1:0] tavg);
    logic [DIST_W-1:0] d;
    logic [DIST_W-1:0] avg;
    bit                got;
    while ($urandom_range(99) < snd_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_adc_sample = s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = 1'b0;
    avg = '0;
    if (distance_of(s, d)) got = window_average(d, avg);
    // hand-computed rows override the model
    if (typed) begin
      got = gives_avg;
      avg = tavg;
    end
    if (got) expected_averages.push_back(avg);
    @(negedge clk);
  endtask

  task automatic write_gate(input logic [CFG_IDX_W-1:0] idx, input logic [DIST_W-1:0] v);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == irtm_pkg::REG_GATE_LOW) gate_lo = v;
    else gate_hi = v;
  endtask

  task automatic drain;
    while (expected_averages.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input string want,
                                 input logic [DIST_W-1:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("%0t: %s: expected %s, got %0d", $realtime, what, want, got);
  endtask

  // receiver side
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = ($urandom_range(99) < rcv_idle);
    end
  end

  always @(posedge clk) begin : check_out
    logic [DIST_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        report_mismatch("unexpected average", "none", out_average_distance);
      end else begin
        want = expected_averages.pop_front();
        if (want !== out_average_distance)
          report_mismatch("average_distance", $sformatf("%0d", want), out_average_distance);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [ADC_W-1:0] s;
    gate_phase_t      p;
    int               r;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_adc_sample = '0;
    cfg_we = 1'b0;
    cfg_idx = irtm_pkg::REG_GATE_LOW;
    cfg_wdata = '0;
    gate_lo = 16'd0;
    gate_hi = 16'hFFFF;
    win_fill = 0;
    mismatch_cnt = 0;
    quiet_cycles = 0;
    snd_idle = 37;
    rcv_idle = 88;

    // rejected readings, a window of the nearest reading (588 = 36.75 cm),
    // then a mix of saturated, near-saturation and ordinary readings
    directed_rows = '{
      '{10'd0,    1'b1, 1'b0, 16'd0},
      '{10'd211,  1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b0, 16'd0},
      '{10'd1023, 1'b1, 1'b1, 16'd588},
      '{10'd212,  1'b0, 1'b0, 16'd0},
      '{10'd218,  1'b0, 1'b0, 16'd0},
      '{10'd219,  1'b0, 1'b0, 16'd0},
      '{10'd220,  1'b0, 1'b0, 16'd0},
      '{10'd400,  1'b0, 1'b0, 16'd0},
      '{10'd700,  1'b0, 1'b0, 16'd0},
      '{10'd1022, 1'b0, 1'b0, 16'd0},
      '{10'd1023, 1'b0, 1'b0, 16'd0},
      '{10'd212,  1'b0, 1'b0, 16'd0},
      '{10'd218,  1'b0, 1'b0, 16'd0}
    };

    // lo, hi, sample span, words, sender idle %, receiver idle %
    gate_phases = '{
      '{16'd0,     16'd65535, 0,    1023, 300, 37, 88},
      '{16'd1000,  16'd4000,  300,  720,  300, 37, 88},
      '{16'd65535, 16'd65535, 205,  225,  150, 88, 37},
      '{16'd5000,  16'd2000,  212,  1023, 40,  88, 37},
      '{16'd0,     16'd0,     0,    1023, 20,  88, 37},
      '{16'd588,   16'd588,   1020, 1023, 80,  88, 37},
      '{16'd0,     16'd65535, 212,  1023, 400, 0,  0}
    };

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[k])
      feed_reading(directed_rows[k].sample, directed_rows[k].typed,
                   directed_rows[k].gives_avg, directed_rows[k].avg);
    in_valid = 1'b0;
    drain();

    foreach (gate_phases[k]) begin
      p = gate_phases[k];
      write_gate(irtm_pkg::REG_GATE_LOW, p.lo);
      write_gate(irtm_pkg::REG_GATE_HIGH, p.hi);
      snd_idle = p.snd_idle;
      rcv_idle = p.rcv_idle;
      repeat (p.count) begin
        r = $urandom_range(99);
        if (r < 80) begin
          s = ADC_W'($urandom_range(p.smax, p.smin));
        end else if (r < 90) begin
          s = ADC_W'($urandom_range(1023, 0));
        end else begin
          // rejection edge, saturation edge and the near end
          case ($urandom_range(5))
            0: s = 10'd0;
            1: s = 10'd211;
            2: s = 10'd212;
            3: s = 10'd218;
            4: s = 10'd219;
            default: s = 10'd1023;
          endcase
        end
        feed_reading(s, 1'b0, 1'b0, '0);
      end
      in_valid = 1'b0;
      drain();
    end

    if (mismatch_cnt == 0 && expected_averages.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
